FILE: rtl/core/lesf_pkg.sv
// Shared constants, register codes and pipeline types of the largest empty square finder.
package lesf_pkg;

  // Grid limits and derived index widths
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Fixed field widths
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SCORE_W    = 11;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CHAR_W-1:0] OBSTACLE_RESET = CHAR_W'(111);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_OBSTACLE    = 2'd2
  } reg_idx_e;

  // Per-cell control passed from the scan stage to the score stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             is_empty;  // cell is not an obstacle
    logic             on_border; // first row or first column
    logic             top_row;   // first row: no line store data
    logic             row_end;   // last cell of its row
    logic             last;      // last cell of the grid
    logic             hold;      // last cell of a one-cell grid
  } cell_ctl_t;

endpackage

FILE: rtl/core/lesf_intf.sv
// Handshake channel interfaces: cell input, result output, configuration write.
interface lesf_cell_if;
  logic                          valid;
  logic                          ready;
  logic [lesf_pkg::CHAR_W-1:0]   cell_char;
  modport source (output valid, output cell_char, input ready);
  modport sink   (input valid, input cell_char, output ready);
endinterface

interface lesf_result_if;
  logic                          valid;
  logic                          ready;
  logic [lesf_pkg::SCORE_W-1:0]  best_size;
  logic [lesf_pkg::POS_W-1:0]    best_row;
  logic [lesf_pkg::POS_W-1:0]    best_col;
  modport source (output valid, output best_size, output best_row, output best_col,
                  input ready);
  modport sink   (input valid, input best_size, input best_row, input best_col,
                  output ready);
endinterface

interface lesf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lesf_pkg::CFG_IDX_W-1:0]  index;
  logic [lesf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/lesf_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module lesf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/lesf_scan.sv
// Scan stage: configuration registers, raster counters and per-cell control.
module lesf_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lesf_cfg_if.sink                    cfg_i,
  lesf_cell_if.sink                   cell_i,
  input  logic                        accept_ok_i,
  output logic                        acc_o,
  output logic                        restart_o,
  output lesf_pkg::cell_ctl_t         ctl_o
);

  logic [lesf_pkg::COL_W-1:0]  width_last_q, width_last_d;
  logic [lesf_pkg::ROW_W-1:0]  height_last_q, height_last_d;
  logic [lesf_pkg::CHAR_W-1:0] obstacle_q, obstacle_d;
  logic [lesf_pkg::COL_W-1:0]  col_q, col_d;
  logic [lesf_pkg::ROW_W-1:0]  row_q, row_d;
  logic                        cfg_hit;
  logic                        row_end;
  logic                        last;

  assign cfg_i.ready = 1'b1;
  assign cell_i.ready = accept_ok_i;
  assign acc_o = cell_i.valid && accept_ok_i;

  // Register writes; out-of-range dimensions are clamped, kept as last index
  always_comb begin
    width_last_d  = width_last_q;
    height_last_d = height_last_q;
    obstacle_d    = obstacle_q;
    cfg_hit       = 1'b0;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lesf_pkg::REG_GRID_WIDTH: begin
          cfg_hit = 1'b1;
          if (cfg_i.data == '0) begin
            width_last_d = '0;
          end else if (32'(cfg_i.data) > lesf_pkg::MAX_WIDTH) begin
            width_last_d = lesf_pkg::COL_W'(lesf_pkg::MAX_WIDTH - 1);
          end else begin
            width_last_d = lesf_pkg::COL_W'(cfg_i.data - 1'b1);
          end
        end
        lesf_pkg::REG_GRID_HEIGHT: begin
          cfg_hit = 1'b1;
          if (cfg_i.data == '0) begin
            height_last_d = '0;
          end else if (32'(cfg_i.data) > lesf_pkg::MAX_HEIGHT) begin
            height_last_d = lesf_pkg::ROW_W'(lesf_pkg::MAX_HEIGHT - 1);
          end else begin
            height_last_d = lesf_pkg::ROW_W'(cfg_i.data - 1'b1);
          end
        end
        lesf_pkg::REG_OBSTACLE: begin
          cfg_hit    = 1'b1;
          obstacle_d = cfg_i.data[lesf_pkg::CHAR_W-1:0];
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  assign restart_o = cfg_hit;

  // Position flags of the current cell
  assign row_end = (col_q == width_last_q);
  assign last    = row_end && (row_q == height_last_q);

  always_comb begin
    ctl_o.col       = col_q;
    ctl_o.row       = row_q;
    ctl_o.is_empty  = (cell_i.cell_char != obstacle_q);
    ctl_o.on_border = (col_q == '0) || (row_q == '0);
    ctl_o.top_row   = (row_q == '0);
    ctl_o.row_end   = row_end;
    ctl_o.last      = last;
    ctl_o.hold      = last && (width_last_q == '0) && (height_last_q == '0);
  end

  // Raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (acc_o) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q  <= '0;
      height_last_q <= '0;
      obstacle_q    <= lesf_pkg::OBSTACLE_RESET;
      col_q         <= '0;
      row_q         <= '0;
    end else begin
      width_last_q  <= width_last_d;
      height_last_q <= height_last_d;
      obstacle_q    <= obstacle_d;
      col_q         <= col_d;
      row_q         <= row_d;
    end
  end

endmodule

FILE: rtl/core/lesf_score.sv
// Score stage: square score from the line store, best tracking and result register.
module lesf_score (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic                          restart_i,
  input  lesf_pkg::cell_ctl_t           ctl_i,
  input  logic [lesf_pkg::SCORE_W-1:0]  rdata_i,
  output logic                          we_o,
  output logic [lesf_pkg::COL_W-1:0]    waddr_o,
  output logic [lesf_pkg::SCORE_W-1:0]  wdata_o,
  output logic                          accept_ok_o,
  lesf_result_if.source                 result_o
);

  lesf_pkg::cell_ctl_t          s1_q;
  logic                         s1_valid_q;
  logic                         fwd_q, fwd_d;
  logic [lesf_pkg::SCORE_W-1:0] fwd_data_q;
  logic [lesf_pkg::SCORE_W-1:0] left_q, left_d;
  logic [lesf_pkg::SCORE_W-1:0] diag_q, diag_d;
  logic [lesf_pkg::SCORE_W-1:0] max_size_q, max_size_d;
  logic [lesf_pkg::ROW_W-1:0]   max_row_q, max_row_d;
  logic [lesf_pkg::COL_W-1:0]   max_col_q, max_col_d;
  logic [lesf_pkg::SCORE_W-1:0] up;
  logic [lesf_pkg::SCORE_W-1:0] low;
  logic [lesf_pkg::SCORE_W-1:0] score;
  logic                         better;
  logic [lesf_pkg::ROW_W-1:0]   top_row;
  logic [lesf_pkg::COL_W-1:0]   left_col;
  logic                         out_valid_q, out_valid_d;
  logic [lesf_pkg::SCORE_W-1:0] out_size_q;
  logic [lesf_pkg::ROW_W-1:0]   out_row_q;
  logic [lesf_pkg::COL_W-1:0]   out_col_q;

  // Only a last cell waits for room in the result register; one-cell grids emit
  // every cell, so they also leave a gap behind each item
  assign accept_ok_o = !(ctl_i.last && out_valid_q && !result_o.ready) &&
                       !(s1_valid_q && s1_q.hold);

  // Score of the previous item, forwarded when it is written as this one reads
  assign fwd_d = acc_i && s1_valid_q && (s1_q.col == ctl_i.col);

  always_comb begin
    if (s1_q.top_row) begin
      up = '0;
    end else if (fwd_q) begin
      up = fwd_data_q;
    end else begin
      up = rdata_i;
    end
  end

  // Minimum of up, left and diagonal, plus one; zero for an obstacle, one on the border
  always_comb begin
    low = diag_q;
    if (up < low) begin
      low = up;
    end
    if (left_q < low) begin
      low = left_q;
    end
    priority if (!s1_q.is_empty) begin
      score = '0;
    end else if (s1_q.on_border) begin
      score = lesf_pkg::SCORE_W'(1);
    end else begin
      score = low + 1'b1;
    end
  end

  // Top-left corner of the square ending at this cell
  assign better   = score > max_size_q;
  assign top_row  = lesf_pkg::ROW_W'(32'(s1_q.row) + 32'd1 - 32'(score));
  assign left_col = lesf_pkg::COL_W'(32'(s1_q.col) + 32'd1 - 32'(score));

  // Line store write-back
  assign we_o    = s1_valid_q;
  assign waddr_o = s1_q.col;
  assign wdata_o = score;

  // Neighbor scores and best square
  always_comb begin
    left_d     = left_q;
    diag_d     = diag_q;
    max_size_d = max_size_q;
    max_row_d  = max_row_q;
    max_col_d  = max_col_q;
    if (better) begin
      max_size_d = score;
      max_row_d  = top_row;
      max_col_d  = left_col;
    end
    if (restart_i || (s1_valid_q && s1_q.last)) begin
      left_d     = '0;
      diag_d     = '0;
      max_size_d = '0;
      max_row_d  = '0;
      max_col_d  = '0;
    end else if (s1_valid_q) begin
      left_d = s1_q.row_end ? '0 : score;
      diag_d = s1_q.row_end ? '0 : up;
    end else begin
      max_size_d = max_size_q;
      max_row_d  = max_row_q;
      max_col_d  = max_col_q;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_valid_q && s1_q.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      left_q      <= '0;
      diag_q      <= '0;
      max_size_q  <= '0;
      max_row_q   <= '0;
      max_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= acc_i;
      fwd_q       <= fwd_d;
      left_q      <= left_d;
      diag_q      <= diag_d;
      max_size_q  <= max_size_d;
      max_row_q   <= max_row_d;
      max_col_q   <= max_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= ctl_i;
    end
    fwd_data_q <= score;
    if (s1_valid_q && s1_q.last) begin
      out_size_q <= better ? score : max_size_q;
      out_row_q  <= better ? top_row : max_row_q;
      out_col_q  <= better ? left_col : max_col_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.best_size = out_size_q;
  assign result_o.best_row  = lesf_pkg::POS_W'(out_row_q);
  assign result_o.best_col  = lesf_pkg::POS_W'(out_col_q);

endmodule

FILE: rtl/core/largest_empty_square_finder_top.sv
// Top level of the largest empty square finder.
// Cells enter in raster order, one item per clock unless stalled, and each cell is
// scored with the maximal-square recurrence against a line store that holds the
// previous row's scores (a registered-read RAM, one read and one write per cell,
// with forwarding when consecutive cells share a column). A cell first reads the
// line store, then is scored and written back. On the last cell of a grid the best
// size and the top-left row and column are captured in an output register when that
// cell is scored; new cells keep flowing while it waits to be taken, and only the
// next grid's last cell stalls until the result register has room. In a one-cell
// grid the block cannot take a new cell while the previous one is still scored.
// The line store needs no clearing after reset; the first row of each grid fills
// it. Any write to a known register restarts the current grid.
module largest_empty_square_finder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  lesf_cfg_if.sink       cfg_i,
  lesf_cell_if.sink      cell_i,
  lesf_result_if.source  result_o
);

  logic                          acc;
  logic                          restart;
  logic                          accept_ok;
  lesf_pkg::cell_ctl_t           ctl;
  logic [lesf_pkg::SCORE_W-1:0]  rdata;
  logic                          we;
  logic [lesf_pkg::COL_W-1:0]    waddr;
  logic [lesf_pkg::SCORE_W-1:0]  wdata;

  // Configuration and raster position
  lesf_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .cell_i      (cell_i),
    .accept_ok_i (accept_ok),
    .acc_o       (acc),
    .restart_o   (restart),
    .ctl_o       (ctl)
  );

  // Previous-row score store
  lesf_ram #(
    .WIDTH (lesf_pkg::SCORE_W),
    .DEPTH (lesf_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (acc),
    .raddr_i (ctl.col),
    .rdata_o (rdata)
  );

  // Scoring, best tracking and result
  lesf_score u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .restart_i   (restart),
    .ctl_i       (ctl),
    .rdata_i     (rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .accept_ok_o (accept_ok),
    .result_o    (result_o)
  );

endmodule
